// File: sv/multitouch_frame_tracker_assert.svh
// Assertion macros for the multitouch frame tracker.
// Uses clk and rst from the including module's scope.
`ifndef MULTITOUCH_FRAME_TRACKER_ASSERT_SVH
`define MULTITOUCH_FRAME_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define MFT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mft same-cycle check failed");
`define MFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mft next-cycle check failed");
`else
`define MFT_ASSERT_SAME(label, ante, cons)
`define MFT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: sv/mft_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the multitouch frame tracker.
// No dependencies.
package mft_pkg;

  localparam int unsigned CNT_W = 4;
  localparam int unsigned ID_W = 8;
  localparam int unsigned POS_W = 16;
  localparam int unsigned MAX_POINTS_DEF = 10;
  localparam logic [CNT_W-1:0] MAX_POINTS_RST = 4'd10;
  localparam int unsigned READY_BIT = 7;

  localparam logic ACT_HEADER = 1'b0;
  localparam logic ACT_POINT = 1'b1;

  localparam logic [1:0] KIND_CONTACT = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_SYNC = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_RELEASE,
    ST_SYNC
  } state_t;

  typedef struct packed {
    logic wr;
    logic [CNT_W-1:0] wr_idx;
    logic [ID_W-1:0] wr_id;
    logic start;
    logic [CNT_W-1:0] count;
    logic rotate;
    logic shift;
    logic commit;
  } cell_ctrl_t;

endpackage

// File: sv/mft_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for tracker input items and result events.
// Depends on mft_pkg for field widths.
interface mft_item_if;
  logic valid;
  logic ready;
  logic action;
  logic [7:0] status_byte;
  logic [mft_pkg::ID_W-1:0] point_id;
  logic [mft_pkg::POS_W-1:0] pos_x;
  logic [mft_pkg::POS_W-1:0] pos_y;

  modport source(output valid, action, status_byte, point_id, pos_x, pos_y, input ready);
  modport sink(input valid, action, status_byte, point_id, pos_x, pos_y, output ready);
endinterface

interface mft_event_if;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic [mft_pkg::ID_W-1:0] slot;
  logic [mft_pkg::POS_W-1:0] out_x;
  logic [mft_pkg::POS_W-1:0] out_y;
  logic last;

  modport source(output valid, kind, slot, out_x, out_y, last, input ready);
  modport sink(input valid, kind, slot, out_x, out_y, last, output ready);
endinterface

// File: sv/multitouch_frame_tracker.sv
`timescale 1ns / 1ps
// Multitouch frame tracker: contact events per point, releases and sync at frame end.
// A contact event is registered and presented in the cycle after its point transaction is taken.
// Frame end: the ids rotate through the cell ring (ST_COMPARE), then each previous
// id is checked in turn and released if absent (ST_RELEASE), then the sync (ST_SYNC).
// Other items: one per cycle while idle and the result register is free or draining.
// Reset (rst, synchronous): counts, frame state and output valid clear; max_points = 10.
`include "multitouch_frame_tracker_assert.svh"
module multitouch_frame_tracker #(
  parameter int unsigned MAX_POINTS = mft_pkg::MAX_POINTS_DEF
) (
  input  logic clk,
  input  logic rst,
  mft_item_if.sink items,
  mft_event_if.source events,
  input  logic cfg_we,
  input  logic [mft_pkg::CNT_W-1:0] cfg_data
);

  localparam int unsigned CW = mft_pkg::CNT_W;
  localparam int unsigned IW = mft_pkg::ID_W;
  localparam int unsigned PW = mft_pkg::POS_W;
  localparam logic [CW-1:0] MAXP = CW'(MAX_POINTS);
  localparam logic [CW-1:0] MAXP_LAST = CW'(MAX_POINTS - 1);

  mft_pkg::state_t state, state_next;
  mft_pkg::cell_ctrl_t ctrl;

  logic [CW-1:0] max_points;
  logic [CW-1:0] cur_count;
  logic [CW-1:0] exp_count;
  logic [CW-1:0] prev_count;
  logic frame_open;
  logic [CW-1:0] step;

  logic ev_valid;
  logic [1:0] ev_kind;
  logic [IW-1:0] ev_slot;
  logic [PW-1:0] ev_x;
  logic [PW-1:0] ev_y;
  logic ev_last;

  logic out_load;
  logic [1:0] ld_kind;
  logic [IW-1:0] ld_slot;
  logic [PW-1:0] ld_x;
  logic [PW-1:0] ld_y;
  logic ld_last;

  logic can_load;
  logic fire;
  logic [CW-1:0] hdr_cnt;
  logic hdr_ok;
  logic pt_ok;
  logic [CW-1:0] cnt_inc;

  logic [IW-1:0] rot_id [MAX_POINTS];
  logic rot_vld [MAX_POINTS];
  logic [IW-1:0] prev_id [MAX_POINTS];
  logic found [MAX_POINTS];

  genvar gi;
  generate
    for (gi = 0; gi < MAX_POINTS; gi++) begin : g_cell
      logic [IW-1:0] nb_rot_id;
      logic nb_rot_vld;
      logic [IW-1:0] nb_prev_id;
      logic nb_found;
      if (gi == 0) begin : g_head
        assign nb_rot_id = rot_id[MAX_POINTS-1];
        assign nb_rot_vld = rot_vld[MAX_POINTS-1];
      end else begin : g_body
        assign nb_rot_id = rot_id[gi-1];
        assign nb_rot_vld = rot_vld[gi-1];
      end
      if (gi == MAX_POINTS - 1) begin : g_tail
        assign nb_prev_id = '0;
        assign nb_found = 1'b1;
      end else begin : g_link
        assign nb_prev_id = prev_id[gi+1];
        assign nb_found = found[gi+1];
      end
      mft_cell #(.IDX(gi)) u_cell (
        .clk(clk),
        .ctrl(ctrl),
        .nb_rot_id(nb_rot_id),
        .nb_rot_vld(nb_rot_vld),
        .nb_prev_id(nb_prev_id),
        .nb_found(nb_found),
        .rot_id(rot_id[gi]),
        .rot_vld(rot_vld[gi]),
        .prev_id(prev_id[gi]),
        .found(found[gi])
      );
    end
  endgenerate

  assign can_load = !ev_valid || events.ready;
  assign fire = items.valid && items.ready;
  assign hdr_cnt = items.status_byte[CW-1:0];
  assign hdr_ok = items.status_byte[mft_pkg::READY_BIT] && (hdr_cnt <= max_points)
                  && (hdr_cnt <= MAXP);
  assign pt_ok = frame_open && (cur_count < MAXP);
  assign cnt_inc = cur_count + 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      mft_pkg::ST_IDLE: begin
        if (ctrl.start) state_next = mft_pkg::ST_COMPARE;
      end
      mft_pkg::ST_COMPARE: begin
        if (step == MAXP_LAST) state_next = mft_pkg::ST_RELEASE;
      end
      mft_pkg::ST_RELEASE: begin
        if (step == prev_count) state_next = mft_pkg::ST_SYNC;
      end
      mft_pkg::ST_SYNC: begin
        if (can_load) state_next = mft_pkg::ST_IDLE;
      end
      default: state_next = mft_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    items.ready = 1'b0;
    ctrl = '0;
    out_load = 1'b0;
    ld_kind = mft_pkg::KIND_CONTACT;
    ld_slot = '0;
    ld_x = '0;
    ld_y = '0;
    ld_last = 1'b0;
    unique case (state)
      mft_pkg::ST_IDLE: begin
        items.ready = can_load;
        if (fire) begin
          if (items.action == mft_pkg::ACT_HEADER) begin
            if (hdr_ok && (hdr_cnt == '0)) begin
              ctrl.start = 1'b1;
              ctrl.count = '0;
            end
          end else if (pt_ok) begin
            ctrl.wr = 1'b1;
            ctrl.wr_idx = cur_count;
            ctrl.wr_id = items.point_id;
            out_load = 1'b1;
            ld_kind = mft_pkg::KIND_CONTACT;
            ld_slot = items.point_id;
            ld_x = items.pos_x;
            ld_y = items.pos_y;
            if (cnt_inc >= exp_count) begin
              ctrl.start = 1'b1;
              ctrl.count = cnt_inc;
            end else begin
              ld_last = 1'b1;
            end
          end
        end
      end
      mft_pkg::ST_COMPARE: begin
        ctrl.rotate = 1'b1;
      end
      mft_pkg::ST_RELEASE: begin
        if (step != prev_count) begin
          if (found[0]) begin
            ctrl.shift = 1'b1;
          end else if (can_load) begin
            ctrl.shift = 1'b1;
            out_load = 1'b1;
            ld_kind = mft_pkg::KIND_RELEASE;
            ld_slot = prev_id[0];
          end
        end
      end
      mft_pkg::ST_SYNC: begin
        if (can_load) begin
          out_load = 1'b1;
          ld_kind = mft_pkg::KIND_SYNC;
          ld_last = 1'b1;
          ctrl.commit = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mft_pkg::ST_IDLE;
      max_points <= mft_pkg::MAX_POINTS_RST;
      cur_count <= '0;
      exp_count <= '0;
      prev_count <= '0;
      frame_open <= 1'b0;
      step <= '0;
      ev_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        max_points <= cfg_data;
      end
      if (state == mft_pkg::ST_COMPARE) begin
        step <= (step == MAXP_LAST) ? '0 : step + 1'b1;
      end else if (ctrl.shift) begin
        step <= step + 1'b1;
      end else if (state != mft_pkg::ST_RELEASE) begin
        step <= '0;
      end
      if (fire && (items.action == mft_pkg::ACT_HEADER) && hdr_ok) begin
        cur_count <= '0;
        exp_count <= hdr_cnt;
        frame_open <= 1'b1;
      end else if (ctrl.wr) begin
        cur_count <= cnt_inc;
      end
      if (ctrl.commit) begin
        prev_count <= cur_count;
        frame_open <= 1'b0;
      end
      if (out_load) begin
        ev_valid <= 1'b1;
      end else if (events.ready) begin
        ev_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ev_kind <= ld_kind;
      ev_slot <= ld_slot;
      ev_x <= ld_x;
      ev_y <= ld_y;
      ev_last <= ld_last;
    end
  end

  assign events.valid = ev_valid;
  assign events.kind = ev_kind;
  assign events.slot = ev_slot;
  assign events.out_x = ev_x;
  assign events.out_y = ev_y;
  assign events.last = ev_last;

  `MFT_ASSERT_SAME(a_ready_idle, items.ready, state == mft_pkg::ST_IDLE)
  `MFT_ASSERT_SAME(a_count_bound, 1'b1, (cur_count <= MAXP) && (prev_count <= MAXP))
  `MFT_ASSERT_SAME(a_sync_last, events.valid && (events.kind == mft_pkg::KIND_SYNC), events.last)
  `MFT_ASSERT_NEXT(a_commit_close, ctrl.commit, !frame_open && (state == mft_pkg::ST_IDLE))
  `MFT_ASSERT_SAME(a_load_free, out_load, can_load)

endmodule

// File: sv/mft_cell.sv
`timescale 1ns / 1ps
// One track slot: current id, previous id, and a rotating copy of the
// current id for the absent-id search. Depends on mft_pkg.
module mft_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic clk,
  input  mft_pkg::cell_ctrl_t ctrl,
  input  logic [mft_pkg::ID_W-1:0] nb_rot_id,
  input  logic nb_rot_vld,
  input  logic [mft_pkg::ID_W-1:0] nb_prev_id,
  input  logic nb_found,
  output logic [mft_pkg::ID_W-1:0] rot_id,
  output logic rot_vld,
  output logic [mft_pkg::ID_W-1:0] prev_id,
  output logic found
);

  localparam int unsigned CW = mft_pkg::CNT_W;
  localparam logic [CW-1:0] CELL_IDX = CW'(IDX);

  logic [mft_pkg::ID_W-1:0] cur_id;
  logic wr_hit;

  assign wr_hit = ctrl.wr && (ctrl.wr_idx == CELL_IDX);

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      cur_id <= ctrl.wr_id;
    end
    if (ctrl.start) begin
      rot_id <= wr_hit ? ctrl.wr_id : cur_id;
      rot_vld <= CELL_IDX < ctrl.count;
      found <= 1'b0;
    end else if (ctrl.rotate) begin
      rot_id <= nb_rot_id;
      rot_vld <= nb_rot_vld;
      found <= found | (rot_vld && (rot_id == prev_id));
    end else if (ctrl.shift) begin
      found <= nb_found;
    end
    if (ctrl.commit) begin
      prev_id <= cur_id;
    end else if (ctrl.shift) begin
      prev_id <= nb_prev_id;
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for multitouch_frame_tracker: directed and random frames, several max_points values.
// Depends on mft_pkg, mft_ifs and the tracker RTL; a scoreboard predicts every event.
module tb_top;

  typedef struct {
    logic [1:0] kind;
    logic [mft_pkg::ID_W-1:0] slot;
    logic [mft_pkg::POS_W-1:0] x;
    logic [mft_pkg::POS_W-1:0] y;
    logic last;
  } touch_event_t;

  class touch_tracker_board;
    touch_event_t pending[$];
    logic [mft_pkg::ID_W-1:0] prev_ids[mft_pkg::MAX_POINTS_DEF];
    logic [mft_pkg::ID_W-1:0] cur_ids[mft_pkg::MAX_POINTS_DEF];
    int prev_n;
    int cur_n;
    int want_n;
    bit open;
    int limit;
    int mismatches;

    function new();
      foreach (prev_ids[i]) prev_ids[i] = '0;
      foreach (cur_ids[i]) cur_ids[i] = '0;
      prev_n = 0;
      cur_n = 0;
      want_n = 0;
      open = 0;
      limit = int'(mft_pkg::MAX_POINTS_RST);
      mismatches = 0;
    endfunction

    function void set_limit(logic [mft_pkg::CNT_W-1:0] v);
      limit = int'(v);
    endfunction

    function void push_event(logic [1:0] kind, logic [mft_pkg::ID_W-1:0] slot,
                             logic [mft_pkg::POS_W-1:0] x, logic [mft_pkg::POS_W-1:0] y);
      touch_event_t e;
      e.kind = kind;
      e.slot = slot;
      e.x = x;
      e.y = y;
      e.last = 1'b0;
      pending.push_back(e);
    endfunction

    // releases for vanished ids, sync, then current ids become previous
    function void close_frame();
      bit seen;
      for (int i = 0; i < prev_n; i++) begin
        seen = 0;
        for (int j = 0; j < cur_n; j++)
          if (prev_ids[i] == cur_ids[j]) seen = 1;
        if (!seen) push_event(mft_pkg::KIND_RELEASE, prev_ids[i], '0, '0);
      end
      push_event(mft_pkg::KIND_SYNC, '0, '0, '0);
      for (int i = 0; i < cur_n; i++) prev_ids[i] = cur_ids[i];
      prev_n = cur_n;
      open = 0;
    endfunction

    // returns 1 when the transaction is not ignored by the block
    function bit take_item(logic action, logic [7:0] status, logic [mft_pkg::ID_W-1:0] id,
                           logic [mft_pkg::POS_W-1:0] x, logic [mft_pkg::POS_W-1:0] y);
      int mark;
      int cnt;
      touch_event_t tail;
      mark = pending.size();
      if (action == mft_pkg::ACT_HEADER) begin
        cnt = int'(status[3:0]);
        if (!status[mft_pkg::READY_BIT] || cnt > limit ||
            cnt > int'(mft_pkg::MAX_POINTS_DEF)) return 0;
        cur_n = 0;
        want_n = cnt;
        open = 1;
        if (cnt == 0) close_frame();
      end else begin
        if (!open || cur_n >= int'(mft_pkg::MAX_POINTS_DEF)) return 0;
        push_event(mft_pkg::KIND_CONTACT, id, x, y);
        cur_ids[cur_n] = id;
        cur_n++;
        if (cur_n >= want_n) close_frame();
      end
      if (pending.size() > mark) begin
        tail = pending.pop_back();
        tail.last = 1'b1;
        pending.push_back(tail);
      end
      return 1;
    endfunction

    function void check_event(logic [1:0] kind, logic [mft_pkg::ID_W-1:0] slot,
                              logic [mft_pkg::POS_W-1:0] x, logic [mft_pkg::POS_W-1:0] y,
                              logic last);
      touch_event_t want;
      if (pending.size() == 0) begin
        $error("unexpected event: kind %0d slot %0d", kind, slot);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, kind);
        mismatches++;
      end
      if (slot !== want.slot) begin
        $error("slot: expected %0d, got %0d", want.slot, slot);
        mismatches++;
      end
      if (x !== want.x) begin
        $error("out_x: expected %0d, got %0d", want.x, x);
        mismatches++;
      end
      if (y !== want.y) begin
        $error("out_y: expected %0d, got %0d", want.y, y);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [mft_pkg::CNT_W-1:0] cfg_data;

  mft_item_if item_ch();
  mft_event_if event_ch();

  multitouch_frame_tracker uut (
    .clk(clk),
    .rst(rst),
    .items(item_ch),
    .events(event_ch),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  touch_tracker_board board = new();
  bit src_fast;
  bit sink_fast;
  int live_items;
  logic [mft_pkg::ID_W-1:0] recent_ids[mft_pkg::MAX_POINTS_DEF];
  int recent_n;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && event_ch.valid === 1'b1 && event_ch.ready === 1'b1)
      board.check_event(event_ch.kind, event_ch.slot, event_ch.out_x, event_ch.out_y,
                        event_ch.last);
  end

  // result side: random stalls, fast stretches, one long hold-off
  initial begin
    int stall;
    int taken;
    bit held;
    event_ch.ready = 1'b0;
    taken = 0;
    held = 0;
    sink_fast = 0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = sink_fast ? 0 : $urandom_range(0, 15);
      if (!held && taken == 120) begin
        stall = 400;
        held = 1;
      end
      @(negedge clk);
      if (stall > 0) begin
        event_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      event_ch.ready <= 1'b1;
      do @(posedge clk); while (event_ch.valid !== 1'b1);
      taken++;
      if ($urandom_range(0, 15) == 0) sink_fast = !sink_fast;
    end
  end

  task automatic drive_item(input logic action, input logic [7:0] status,
                            input logic [mft_pkg::ID_W-1:0] id,
                            input logic [mft_pkg::POS_W-1:0] x,
                            input logic [mft_pkg::POS_W-1:0] y);
    int gap;
    gap = src_fast ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 19) == 0) src_fast = !src_fast;
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.action <= action;
    item_ch.status_byte <= status;
    item_ch.point_id <= id;
    item_ch.pos_x <= x;
    item_ch.pos_y <= y;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    if (board.take_item(action, status, id, x, y)) live_items++;
  endtask

  function automatic logic [mft_pkg::ID_W-1:0] pick_id();
    if (recent_n > 0 && $urandom_range(0, 3) != 0)
      return recent_ids[$urandom_range(0, recent_n - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // header for n points, then the first min(n, cut) of them
  task automatic play_frame(int n, int cut);
    logic [mft_pkg::ID_W-1:0] ids[mft_pkg::MAX_POINTS_DEF];
    logic [7:0] st;
    logic [mft_pkg::ID_W-1:0] id;
    st = 8'($urandom);
    st[mft_pkg::READY_BIT] = 1'b1;
    st[3:0] = 4'(n);
    drive_item(mft_pkg::ACT_HEADER, st, 8'($urandom), 16'($urandom), 16'($urandom));
    for (int k = 0; k < n && k < cut; k++) begin
      id = pick_id();
      ids[k] = id;
      drive_item(mft_pkg::ACT_POINT, 8'($urandom), id, 16'($urandom), 16'($urandom));
    end
    if (cut >= n) begin
      for (int k = 0; k < n; k++) recent_ids[k] = ids[k];
      recent_n = n;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(logic [mft_pkg::CNT_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_limit(v);
  endtask

  task automatic run_phase(logic [mft_pkg::CNT_W-1:0] lim, int target);
    int stop;
    int cap;
    int r;
    int n;
    logic [7:0] st;
    write_limit(lim);
    cap = (int'(lim) > int'(mft_pkg::MAX_POINTS_DEF)) ? int'(mft_pkg::MAX_POINTS_DEF)
                                                      : int'(lim);
    stop = live_items + target;
    while (live_items < stop) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        play_frame($urandom_range(0, cap), int'(mft_pkg::MAX_POINTS_DEF));
      end else if (r < 80 && cap > 0) begin
        n = $urandom_range(1, cap);
        play_frame(n, $urandom_range(0, n - 1));
      end else if (r < 88) begin
        drive_item(mft_pkg::ACT_HEADER, 8'($urandom_range(0, 127)), 8'($urandom),
                   16'($urandom), 16'($urandom));
      end else if (r < 94 && cap < 15) begin
        st = 8'($urandom);
        st[mft_pkg::READY_BIT] = 1'b1;
        st[3:0] = 4'($urandom_range(cap + 1, 15));
        drive_item(mft_pkg::ACT_HEADER, st, 8'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        drive_item(mft_pkg::ACT_POINT, 8'($urandom), pick_id(), 16'($urandom),
                   16'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.action = mft_pkg::ACT_HEADER;
    item_ch.status_byte = '0;
    item_ch.point_id = '0;
    item_ch.pos_x = '0;
    item_ch.pos_y = '0;
    src_fast = 0;
    live_items = 0;
    recent_n = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // not ready header, stray point, corner coordinates
    drive_item(mft_pkg::ACT_HEADER, 8'h0F, 8'h00, 16'h0000, 16'h0000);
    drive_item(mft_pkg::ACT_POINT, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF);
    drive_item(mft_pkg::ACT_HEADER, 8'h82, 8'h00, 16'h0000, 16'h0000);
    drive_item(mft_pkg::ACT_POINT, 8'h00, 8'h00, 16'h0000, 16'h0000);
    drive_item(mft_pkg::ACT_POINT, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    // count above limit, then a frame abandoned by a new header
    drive_item(mft_pkg::ACT_HEADER, 8'h8B, 8'h00, 16'h0000, 16'h0000);
    drive_item(mft_pkg::ACT_HEADER, 8'h83, 8'h00, 16'h0000, 16'h0000);
    drive_item(mft_pkg::ACT_POINT, 8'h00, 8'h00, 16'h1234, 16'h5678);
    drive_item(mft_pkg::ACT_HEADER, 8'h81, 8'h00, 16'h0000, 16'h0000);
    drive_item(mft_pkg::ACT_POINT, 8'h00, 8'h55, 16'hAAAA, 16'h5555);
    // repeated id, released once per entry later
    drive_item(mft_pkg::ACT_HEADER, 8'h82, 8'h00, 16'h0000, 16'h0000);
    drive_item(mft_pkg::ACT_POINT, 8'h00, 8'h55, 16'h0001, 16'h8000);
    drive_item(mft_pkg::ACT_POINT, 8'h00, 8'h55, 16'h8000, 16'h0001);
    drive_item(mft_pkg::ACT_HEADER, 8'h8A, 8'h00, 16'h0000, 16'h0000);
    for (int k = 0; k < int'(mft_pkg::MAX_POINTS_DEF); k++)
      drive_item(mft_pkg::ACT_POINT, 8'h00, 8'(8'hA0 + k), 16'($urandom), 16'($urandom));
    // one new point releases all ten: twelve events
    drive_item(mft_pkg::ACT_HEADER, 8'h81, 8'h00, 16'h0000, 16'h0000);
    drive_item(mft_pkg::ACT_POINT, 8'h00, 8'h07, 16'hFFFF, 16'h0000);
    drive_item(mft_pkg::ACT_HEADER, 8'h80, 8'h00, 16'h0000, 16'h0000);

    write_limit(4'd0);
    drive_item(mft_pkg::ACT_HEADER, 8'h81, 8'h00, 16'h0000, 16'h0000);
    drive_item(mft_pkg::ACT_HEADER, 8'h80, 8'h00, 16'h0000, 16'h0000);
    write_limit(4'd15);
    drive_item(mft_pkg::ACT_HEADER, 8'h8C, 8'h00, 16'h0000, 16'h0000);
    play_frame(2, int'(mft_pkg::MAX_POINTS_DEF));
    write_limit(4'd1);
    drive_item(mft_pkg::ACT_HEADER, 8'h82, 8'h00, 16'h0000, 16'h0000);
    play_frame(1, int'(mft_pkg::MAX_POINTS_DEF));

    run_phase(4'd4, 75);
    run_phase(4'd10, 75);
    run_phase(4'd1, 60);
    run_phase(4'd15, 75);
    run_phase(4'($urandom_range(1, 10)), 75);
    run_phase(4'd7, 75);

    drain();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
